// ===== hdl/huffman_tree_stream_decoder_unit_assert.svh =====
// assertion macros for the huffman tree stream decoder
// used by the decoder core and the top level
`ifndef HUFFMAN_TREE_STREAM_DECODER_UNIT_ASSERT_SVH
`define HUFFMAN_TREE_STREAM_DECODER_UNIT_ASSERT_SVH
// clocked property with async reset disable
`define HTSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication checked in the following cycle
`define HTSD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`endif

// ===== hdl/htsd_pkg.sv =====
// shared types and constants for the huffman tree stream decoder
// no dependencies
package htsd_pkg;
  localparam int unsigned RefW = 9;
  localparam int unsigned LeafFlagBit = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       error;
  } out_word_t;
endpackage

// ===== hdl/huffman_tree_stream_decoder_unit.sv =====
// channel | signals                          | dir
// in      | in_valid_i in_ready_o in_byte_i start_entry_i | to block
// out     | out_valid_o out_ready_i symbol_o last_o error_o | from block
// a byte is dropped when no tree is loaded or after a failure; any other byte is accepted,
// then each load bit is stepped, each decode bit waits on the registered node read, each leaf
// takes a further step, and the held symbol is released at the end of the byte
// reset leaves the phase idle; the node stores are not cleared
// a two-word queue takes bytes while the core works; the core stalls on a full output
// top level of the huffman tree stream decoder
// depends on htsd_pkg, htsd_in_fifo, htsd_core and the assertion macro header
`include "huffman_tree_stream_decoder_unit_assert.svh"
module huffman_tree_stream_decoder_unit
  import htsd_pkg::*;
#(
  parameter int unsigned MaxBranches = 255,
  parameter int unsigned MaxLeaves   = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       start_entry_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] symbol_o,
  output logic       last_o,
  output logic       error_o
);
  in_word_t  fin, fout;
  logic      fvalid, fready;
  out_word_t ow;

  assign fin = '{data: in_byte_i, start: start_entry_i};

  htsd_in_fifo u_fifo (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .ready_o(in_ready_o), .word_i(fin),
    .valid_o(fvalid), .ready_i(fready), .word_o(fout)
  );

  htsd_core #(.MaxBranches(MaxBranches), .MaxLeaves(MaxLeaves)) u_core (
    .clk_i, .rst_ni,
    .valid_i(fvalid), .ready_o(fready), .word_i(fout),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .word_o(ow)
  );

  assign symbol_o = ow.symbol;
  assign last_o   = ow.last;
  assign error_o  = ow.error;

  `HTSD_ASSERT(a_err_sym, !(out_valid_o && error_o) || (symbol_o == 8'd0),
    "error word carries a symbol")
  `HTSD_ASSERT(a_err_last, !(out_valid_o && error_o) || last_o, "error word not last")
  `HTSD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(symbol_o),
    "stalled output changed")
endmodule

// ===== hdl/htsd_in_fifo.sv =====
// front queue: holds accepted input words ahead of the decoder core
// depends on htsd_pkg
module htsd_in_fifo
  import htsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_word_t word_i,
  output logic     valid_o,
  input  logic     ready_i,
  output in_word_t word_o
);
  in_word_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign word_o  = mem_q[rp_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== hdl/htsd_core.sv =====
// back end: loads the serialized tree and walks it, one bit per step
// depends on htsd_pkg and the assertion macro header
`include "huffman_tree_stream_decoder_unit_assert.svh"
module htsd_core
  import htsd_pkg::*;
#(
  parameter int unsigned MaxBranches = 255,
  parameter int unsigned MaxLeaves   = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  in_word_t  word_i,
  output logic      valid_o,
  input  logic      ready_i,
  output out_word_t word_o
);
  localparam int unsigned BrW = (MaxBranches > 1) ? $clog2(MaxBranches) : 1;
  localparam int unsigned BcW = $clog2(MaxBranches + 1);
  localparam int unsigned LfW = $clog2(MaxLeaves);
  localparam int unsigned LcW = $clog2(MaxLeaves + 1);

  typedef enum logic [1:0] {PhIdle, PhLoad, PhDecode, PhFail} phase_e;
  typedef enum logic [1:0] {StIdle, StRun, StLeaf, StOut} state_e;

  logic [2*RefW-1:0] kids_mem [MaxBranches];
  logic [7:0]        leaf_mem [MaxLeaves];
  logic [RefW-1:0]   stack_mem [MaxBranches];

  state_e          state_q;
  phase_e          phase_q;
  logic [7:0]      byte_q;
  logic [2:0]      bit_q;
  logic [BcW-1:0]  bcnt_q;
  logic [LcW-1:0]  lcnt_q;
  logic [BcW-1:0]  depth_q;
  logic [RefW-1:0] top_q;
  logic [7:0]      shift_q;
  logic [3:0]      lbits_q;
  logic [BrW-1:0]  node_q;
  logic [LfW-1:0]  li_q;
  logic            ovalid_q;
  out_word_t       oword_q;
  logic            pend_q;
  logic [7:0]      psym_q;

  logic [2*RefW-1:0] kids_rd;
  logic [RefW-1:0]   stack_rd;
  logic [7:0]        leaf_rd;
  logic              cur_bit;
  logic              is_last_bit;
  logic [RefW-1:0]   dref;

  assign ready_o     = (state_q == StIdle) && !pend_q;
  assign valid_o     = ovalid_q;
  assign word_o      = oword_q;
  assign cur_bit     = byte_q[bit_q];
  assign is_last_bit = (bit_q == 3'd0);
  assign dref        = cur_bit ? kids_rd[2*RefW-1:RefW] : kids_rd[RefW-1:0];

  // registered reads: kids at node_q (decode) or at top (load), stack top below pushed top, leaf value
  logic [BrW-1:0] kids_ra;
  logic [BrW-1:0] stack_ra;
  logic [LfW-1:0] leaf_ra;
  assign leaf_ra = (state_q == StOut) ? dref[LfW-1:0] : li_q;
  always_ff @(posedge clk_i) begin
    kids_rd  <= kids_mem[kids_ra];
    stack_rd <= stack_mem[stack_ra];
    leaf_rd  <= leaf_mem[leaf_ra];
  end

  // write ports, driven from the control block
  logic            kids_we;
  logic [BrW-1:0]  kids_wa;
  logic [2*RefW-1:0] kids_wd;
  logic            stack_we;
  logic [BrW-1:0]  stack_wa;
  logic [RefW-1:0] stack_wd;
  logic            leaf_we;
  logic [LfW-1:0]  leaf_wa;

  always_ff @(posedge clk_i) begin
    if (kids_we) kids_mem[kids_wa] <= kids_wd;
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    if (leaf_we) leaf_mem[leaf_wa] <= shift_q;
  end

  logic [BrW-1:0] top_idx;
  logic [BcW-1:0] depth_m2;
  assign top_idx  = top_q[BrW-1:0];
  assign depth_m2 = depth_q - BcW'(2);

  // combinational step logic
  logic            step_fail;
  logic            need_pop;
  logic            attach;
  logic [RefW-1:0] attach_ref;
  logic            push_br;

  always_comb begin
    step_fail  = 1'b0;
    attach     = 1'b0;
    attach_ref = '0;
    push_br    = 1'b0;
    if (lbits_q == 4'd0) begin
      if (cur_bit) begin
        if (bcnt_q == '0 || lcnt_q >= LcW'(MaxLeaves)) begin
          step_fail = 1'b1;
        end else begin
          attach     = 1'b1;
          attach_ref = {1'b1, 8'(lcnt_q)};
        end
      end else begin
        if (bcnt_q >= BcW'(MaxBranches)) begin
          step_fail = 1'b1;
        end else begin
          attach     = 1'b1;
          attach_ref = {1'b0, 8'(bcnt_q)};
          push_br    = 1'b1;
        end
      end
    end
    need_pop = attach && top_q[LeafFlagBit] && (depth_q != '0);
  end

  // kids read address: decode walks node_q, load reads the open branch at top
  // the slot pair of the open branch is kept by read-modify via kids_rd of top
  assign kids_ra  = (phase_q == PhDecode) ? node_q : top_idx;
  assign stack_ra = BrW'(depth_m2);

  // load keeps top's sibling half in kids_rd: kids_ra is top_idx, stable the cycle before
  always_comb begin
    kids_we  = 1'b0;
    kids_wa  = top_idx;
    kids_wd  = kids_rd;
    stack_we = 1'b0;
    stack_wa = BrW'(depth_q);
    stack_wd = top_q;
    leaf_we  = 1'b0;
    leaf_wa  = LfW'(lcnt_q - LcW'(1));
    if (state_q == StRun && phase_q == PhLoad) begin
      if (lbits_q != 4'd0) begin
        leaf_we = (lbits_q == 4'd8) ? 1'b0 : 1'b0;
      end else if (attach && depth_q != '0) begin
        kids_we = 1'b1;
        if (!top_q[LeafFlagBit]) kids_wd = {kids_rd[2*RefW-1:RefW], attach_ref};
        else kids_wd = {attach_ref, kids_rd[RefW-1:0]};
      end
      if (push_br && depth_q != '0) begin
        // spill the current top (with its updated flag) below the new one
        stack_we = 1'b1;
        stack_wa = BrW'(depth_q - BcW'(1));
        stack_wd = top_q[LeafFlagBit] ? top_q : {1'b1, top_q[7:0]};
      end
    end
    if (state_q == StLeaf && phase_q == PhLoad) begin
      leaf_we = 1'b1;
    end
  end

  logic [7:0] shift_n;
  assign shift_n = {shift_q[6:0], cur_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      phase_q  <= PhIdle;
      byte_q   <= '0;
      bit_q    <= '0;
      bcnt_q   <= '0;
      lcnt_q   <= '0;
      depth_q  <= '0;
      top_q    <= '0;
      shift_q  <= '0;
      lbits_q  <= '0;
      node_q   <= '0;
      li_q     <= '0;
      ovalid_q <= 1'b0;
      oword_q  <= '0;
      pend_q   <= 1'b0;
      psym_q   <= '0;
    end else begin
      if (ovalid_q && ready_i) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (pend_q) begin
            // held symbol is the last of its byte
            if (!(ovalid_q && !ready_i)) begin
              ovalid_q <= 1'b1;
              oword_q  <= '{symbol: psym_q, last: 1'b1, error: 1'b0};
              pend_q   <= 1'b0;
            end
          end else if (valid_i) begin
            byte_q <= word_i.data;
            bit_q  <= 3'd7;
            if (word_i.start) begin
              phase_q <= PhLoad;
              bcnt_q  <= '0;
              lcnt_q  <= '0;
              depth_q <= '0;
              shift_q <= '0;
              lbits_q <= '0;
              node_q  <= '0;
              state_q <= StRun;
            end else if (phase_q == PhLoad || phase_q == PhDecode) begin
              state_q <= StRun;
            end
          end
        end
        StRun: begin
          if (!(ovalid_q && !ready_i)) begin
            if (phase_q == PhLoad) begin
              if (lbits_q != 4'd0) begin
                shift_q <= shift_n;
                lbits_q <= lbits_q + 4'd1;
                if (lbits_q == 4'd8) begin
                  shift_q <= shift_n;
                  lbits_q <= '0;
                  state_q <= StLeaf;
                end else if (is_last_bit) begin
                  state_q <= StIdle;
                end else begin
                  bit_q <= bit_q - 3'd1;
                end
              end else if (step_fail) begin
                phase_q  <= PhFail;
                ovalid_q <= 1'b1;
                oword_q  <= '{symbol: 8'd0, last: 1'b1, error: 1'b1};
                state_q  <= StIdle;
              end else begin
                if (cur_bit) begin
                  lcnt_q  <= lcnt_q + LcW'(1);
                  shift_q <= '0;
                  lbits_q <= 4'd1;
                  if (need_pop) begin
                    depth_q <= depth_q - BcW'(1);
                    state_q <= StOut;
                  end else begin
                    top_q <= {1'b1, top_q[7:0]};
                  end
                end else begin
                  bcnt_q  <= bcnt_q + BcW'(1);
                  depth_q <= depth_q + BcW'(1);
                  top_q   <= {1'b0, 8'(bcnt_q)};
                  if (need_pop) begin
                    depth_q <= depth_q;
                  end
                end
                if (!(cur_bit && need_pop)) begin
                  if (is_last_bit) state_q <= StIdle;
                  else bit_q <= bit_q - 3'd1;
                end
              end
            end else begin
              // decode: kids_rd for node_q is registered on the way to StOut
              state_q <= StOut;
            end
          end
        end
        StOut: begin
          // StOut lets the registered memory reads settle after a pop or a node change
          if (phase_q == PhLoad) begin
            // popped: new top read from the stack
            if (depth_q == '0) begin
              top_q <= '0;
            end else begin
              top_q <= stack_rd;
            end
            if (is_last_bit) state_q <= StIdle;
            else begin
              bit_q   <= bit_q - 3'd1;
              state_q <= StRun;
            end
          end else if (!(ovalid_q && !ready_i)) begin
            if (dref[LeafFlagBit]) begin
              li_q    <= dref[LfW-1:0];
              node_q  <= '0;
              state_q <= StLeaf;
            end else begin
              node_q <= dref[BrW-1:0];
              if (is_last_bit) state_q <= StIdle;
              else begin
                bit_q   <= bit_q - 3'd1;
                state_q <= StRun;
              end
            end
          end
        end
        StLeaf: begin
          if (phase_q == PhLoad) begin
            if (depth_q == '0) begin
              phase_q <= PhDecode;
              node_q  <= '0;
            end
            if (is_last_bit) state_q <= StIdle;
            else begin
              bit_q   <= bit_q - 3'd1;
              state_q <= StRun;
            end
          end else if (!(ovalid_q && !ready_i)) begin
            // hold the new symbol, release the previous one of this byte
            psym_q <= leaf_rd;
            pend_q <= 1'b1;
            if (pend_q) begin
              ovalid_q <= 1'b1;
              oword_q  <= '{symbol: psym_q, last: 1'b0, error: 1'b0};
            end
            if (is_last_bit) state_q <= StIdle;
            else begin
              bit_q   <= bit_q - 3'd1;
              state_q <= StRun;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `HTSD_ASSERT(a_depth_bound, depth_q <= BcW'(MaxBranches), "stack depth beyond store")
  `HTSD_ASSERT(a_leaf_bound, lcnt_q <= LcW'(MaxLeaves), "leaf count beyond store")
  `HTSD_ASSERT_NEXT(a_fail_err, state_q == StRun && phase_q == PhLoad && lbits_q == 4'd0
    && step_fail && !(ovalid_q && !ready_i), ovalid_q && oword_q.error, "failure not reported")
endmodule
